// File: rtl/core/fpcs_pkg.sv
// ----------------------------------------------------------------------------
// fpcs_pkg
// Shared types, constants and register indexes of the flux PLL cell separator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpcs_pkg;

	// Field and register widths
	localparam int NOMINAL_W  = 12;
	localparam int PCT_W      = 6;
	localparam int RATIO_W    = 4;
	localparam int REJ_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int INTV_W     = 16;
	localparam int COUNT_W    = 8;
	localparam int ERR_OUT_W  = 16;
	localparam int PHASE_W    = 32;

	// Working width of the phase arithmetic and of the shared divider
	localparam int AW    = 36;
	localparam int DIV_W = 34;

	localparam int DEF_SCALE_SHIFT = 4;
	localparam int MAX_CELLS       = 255;

	// Phase fold
	localparam logic signed [AW-1:0] FOLD_LIMIT = AW'(64'd531628032);
	localparam logic signed [AW-1:0] FOLD_STEP  = AW'(64'd265814016);

	localparam logic [ERR_OUT_W-1:0] ERR_NONE = 16'hFFFF;
	localparam logic [ERR_OUT_W-1:0] ERR_SAT  = 16'hFFFE;

	// x / 100 as (x * PCT_RECIP) >> PCT_RECIP_SHIFT, exact below 2^18
	localparam int PCT_RECIP_W     = 19;
	localparam int PCT_RECIP_SHIFT = 25;
	localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 19'd335545;

	// Rejection modes
	localparam logic [REJ_W-1:0] REJ_NONE = 2'd0;
	localparam logic [REJ_W-1:0] REJ_GCR  = 2'd1;
	localparam logic [REJ_W-1:0] REJ_FM   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_NUM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_DEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_NUM = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_DEN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REJ_MODE = 3'd6;

	// Reset values of the registers
	localparam logic [NOMINAL_W-1:0] NOMINAL_RST  = 12'd96;
	localparam logic [PCT_W-1:0]     WINDOW_RST   = 6'd18;
	localparam logic [RATIO_W-1:0]   FAST_NUM_RST = 4'd1;
	localparam logic [RATIO_W-1:0]   FAST_DEN_RST = 4'd2;
	localparam logic [RATIO_W-1:0]   SLOW_NUM_RST = 4'd3;
	localparam logic [RATIO_W-1:0]   SLOW_DEN_RST = 4'd4;

	typedef struct packed {
		logic [RATIO_W-1:0] fast_num;
		logic [RATIO_W-1:0] fast_den;
		logic [RATIO_W-1:0] slow_num;
		logic [RATIO_W-1:0] slow_den;
		logic [REJ_W-1:0]   rej_mode;
	} cfg_t;

	// Controller to datapath strobes
	typedef struct packed {
		logic load;
		logic prep;
		logic commit_bad;
		logic zero_step;
		logic step_start;
		logic adv;
		logic finish;
		logic mul;
		logic corr_start;
		logic apply;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic bad;
		logic beyond;
		logic cs_zero;
		logic corr;
		logic den_zero;
		logic div_done;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/core/flux_pll_cell_separator.sv
// Flow: an interval is accepted only while the sequencer is idle, after the last item
//   has been handed off; a window step runs on the 34-bit shared divider, one quotient
//   bit per cycle, when the pulse lies beyond the window; correction with a nonzero
//   denominator uses it too. A full output register does not block acceptance, only
//   the final handoff of the next item.
// Reset: phases clear, cell size loads 96 << SCALE_SHIFT, registers take their defaults.
// ----------------------------------------------------------------------------
// flux_pll_cell_separator
// Digital PLL data separator: counts bit cells per flux interval and tracks
// the cell size with a ratio-based phase correction.
// ----------------------------------------------------------------------------
`default_nettype none

module flux_pll_cell_separator import fpcs_pkg::*; #(
	parameter int SCALE_SHIFT = DEF_SCALE_SHIFT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [INTV_W-1:0]     pulse_interval,
	input  wire logic                  phase_correct,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [COUNT_W-1:0]         cell_count,
	output logic                       bad_pulse,
	output logic [ERR_OUT_W-1:0]       phase_error,
	// configuration write port
	input  wire logic                  cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CS_W = NOMINAL_W + 1 + SCALE_SHIFT;
	localparam int PP_W = NOMINAL_W + PCT_W;
	localparam int WF_W = PP_W + PCT_RECIP_W;

	// Configuration registers
	logic [NOMINAL_W-1:0] nominal_q;
	logic [PCT_W-1:0]     pct_q;
	cfg_t                 cfg_q;

	// Clamp limits, registered through pct_prod_q and w_q into lim_lo_q and lim_hi_q
	logic [PP_W-1:0]      pct_prod_q;
	logic [WF_W-1:0]      w_full;
	logic [NOMINAL_W-1:0] w_q;
	logic [CS_W-1:0]      lim_lo_q;
	logic [CS_W-1:0]      lim_hi_q;

	// Output register
	logic                 out_valid_q;
	logic [COUNT_W-1:0]   cell_count_q;
	logic                 bad_pulse_q;
	logic [ERR_OUT_W-1:0] phase_error_q;

	cmd_t                 cmd;
	stat_t                stat;
	logic                 out_free;
	logic                 reload;
	logic [COUNT_W-1:0]   res_count;
	logic                 res_bad;
	logic [ERR_OUT_W-1:0] res_err;

	// Register writes; index 0 also reloads the cell size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q      <= NOMINAL_RST;
			pct_q          <= WINDOW_RST;
			cfg_q.fast_num <= FAST_NUM_RST;
			cfg_q.fast_den <= FAST_DEN_RST;
			cfg_q.slow_num <= SLOW_NUM_RST;
			cfg_q.slow_den <= SLOW_DEN_RST;
			cfg_q.rej_mode <= REJ_NONE;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_NOMINAL:  nominal_q      <= cfg_data[NOMINAL_W-1:0];
				REG_WINDOW:   pct_q          <= cfg_data[PCT_W-1:0];
				REG_FAST_NUM: cfg_q.fast_num <= cfg_data[RATIO_W-1:0];
				REG_FAST_DEN: cfg_q.fast_den <= cfg_data[RATIO_W-1:0];
				REG_SLOW_NUM: cfg_q.slow_num <= cfg_data[RATIO_W-1:0];
				REG_SLOW_DEN: cfg_q.slow_den <= cfg_data[RATIO_W-1:0];
				REG_REJ_MODE: cfg_q.rej_mode <= cfg_data[REJ_W-1:0];
				default: ;
			endcase
		end
	end

	assign reload = cfg_write_en && (cfg_index == REG_NOMINAL);

	// w = nominal * percent / 100 through a reciprocal multiply, then the
	// scaled lower and upper cell size bounds
	assign w_full = WF_W'(pct_prod_q) * WF_W'(PCT_RECIP);

	always_ff @(posedge clk) begin
		pct_prod_q <= PP_W'(nominal_q) * PP_W'(pct_q);
		w_q        <= w_full[PCT_RECIP_SHIFT +: NOMINAL_W];
		lim_lo_q   <= CS_W'(nominal_q - w_q) << SCALE_SHIFT;
		lim_hi_q   <= CS_W'({1'b0, nominal_q} + {1'b0, w_q}) << SCALE_SHIFT;
	end

	fpcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	fpcs_datapath #(
		.SCALE_SHIFT (SCALE_SHIFT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg_q),
		.reload         (reload),
		.reload_nominal (cfg_data[NOMINAL_W-1:0]),
		.lim_lo         (lim_lo_q),
		.lim_hi         (lim_hi_q),
		.in_interval    (pulse_interval),
		.in_corr        (phase_correct),
		.stat           (stat),
		.res_count      (res_count),
		.res_bad        (res_bad),
		.res_err        (res_err)
	);

	// Hold a finished item until taken; the sequencer only hands off when free
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_count_q  <= res_count;
			bad_pulse_q   <= res_bad;
			phase_error_q <= res_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign cell_count  = cell_count_q;
	assign bad_pulse   = bad_pulse_q;
	assign phase_error = phase_error_q;

endmodule

`default_nettype wire

// File: rtl/core/fpcs_div.sv
// ----------------------------------------------------------------------------
// fpcs_div
// Shared restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module fpcs_div #(
	parameter int DIV_W = 34,
	parameter int DVS_W = 17,
	parameter int CNT_W = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	input  wire logic [CNT_W-1:0] iters,
	output logic                  done,
	output logic [DIV_W-1:0]      quo,
	output logic [DVS_W-1:0]      rem
);

	logic             busy_q;
	logic             done_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DVS_W:0]   rem_sh;
	logic             q_bit;
	logic [DVS_W-1:0] rem_nxt;

	assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
	assign q_bit   = rem_sh >= {1'b0, dvs_q};
	assign rem_nxt = q_bit ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
			rem_q <= '0;
			cnt_q <= iters;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DIV_W-2:0], q_bit};
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// File: rtl/core/fpcs_datapath.sv
// ----------------------------------------------------------------------------
// fpcs_datapath
// Phase state, window stepping, band rejection and cell size correction.
// ----------------------------------------------------------------------------
`default_nettype none

module fpcs_datapath import fpcs_pkg::*; #(
	parameter int SCALE_SHIFT = DEF_SCALE_SHIFT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cmd_t                          cmd,
	input  wire cfg_t                          cfg,
	input  wire logic                          reload,
	input  wire logic [NOMINAL_W-1:0]          reload_nominal,
	input  wire logic [NOMINAL_W+SCALE_SHIFT:0] lim_lo,
	input  wire logic [NOMINAL_W+SCALE_SHIFT:0] lim_hi,
	input  wire logic [INTV_W-1:0]             in_interval,
	input  wire logic                          in_corr,
	output stat_t                              stat,
	output logic [COUNT_W-1:0]                 res_count,
	output logic                               res_bad,
	output logic [ERR_OUT_W-1:0]               res_err
);

	localparam int CS_W   = NOMINAL_W + 1 + SCALE_SHIFT;
	localparam int ERR_W  = CS_W + 1;
	localparam int CORR_W = ERR_W + RATIO_W;
	localparam int NW     = CORR_W + 2;
	localparam int CNT_W  = $clog2(DIV_W + 1);
	localparam logic [CS_W-1:0] CS_RST = CS_W'(NOMINAL_RST) << SCALE_SHIFT;

	// Architectural state
	logic [PHASE_W-1:0] wphase_q;
	logic [PHASE_W-1:0] lphase_q;
	logic [CS_W-1:0]    cs_q;

	// Per-item working registers
	logic [INTV_W-1:0]       intv_q;
	logic                    corr_q;
	logic signed [AW-1:0]    ph_q;
	logic signed [AW-1:0]    pos_q;
	logic [COUNT_W-1:0]      count_q;
	logic signed [ERR_W-1:0] err_q;
	logic [CORR_W-1:0]       prod_q;
	logic [COUNT_W-1:0]      res_count_q;
	logic                    res_bad_q;
	logic [ERR_OUT_W-1:0]    res_err_q;

	logic signed [AW-1:0] ph0, la0, ph1, la1, pos1, ivl_s;
	logic                 fold;
	logic signed [AW-1:0] cs_s, half_s, right_s, gap, dvd_s, ph_adv, err_full;
	logic [COUNT_W-1:0]   cnt_adv;
	logic                 err_neg;
	logic [ERR_W-1:0]     mag;
	logic [RATIO_W-1:0]   num_sel, den_sel;
	logic [ERR_OUT_W-1:0] err_sat;

	logic             div_start, div_done;
	logic [DIV_W-1:0] div_dividend, div_quo;
	logic [CS_W-1:0]  div_divisor, div_rem;
	logic [CNT_W-1:0] div_iters;

	logic [CORR_W-1:0]    term;
	logic signed [NW-1:0] cs_ext, term_ext, cs_new, lo_ext, hi_ext, cs_clamp;

	function automatic logic [COUNT_W-1:0] reject(
		input logic [REJ_W-1:0]   mode,
		input logic [COUNT_W-1:0] cnt,
		input logic               early
	);
		logic [COUNT_W-1:0] c;
		c = cnt;
		case (mode)
			REJ_GCR: begin
				if (c == COUNT_W'(3)) c = early ? COUNT_W'(2) : COUNT_W'(4);
				if (c == COUNT_W'(5)) c = early ? COUNT_W'(4) : COUNT_W'(6);
			end
			REJ_FM: begin
				if (c == COUNT_W'(1)) c = COUNT_W'(2);
				if (c == COUNT_W'(3)) c = early ? COUNT_W'(2) : COUNT_W'(4);
				if (c > COUNT_W'(4)) c = COUNT_W'(4);
			end
			default: c = cnt;
		endcase
		return c;
	endfunction

	// Fold the phases and place the pulse
	assign ph0   = {{(AW-PHASE_W){wphase_q[PHASE_W-1]}}, wphase_q};
	assign la0   = {{(AW-PHASE_W){lphase_q[PHASE_W-1]}}, lphase_q};
	assign fold  = ph0 > FOLD_LIMIT;
	assign ph1   = fold ? ph0 - FOLD_STEP : ph0;
	assign la1   = fold ? la0 - FOLD_STEP : la0;
	assign ivl_s = $signed(AW'(intv_q) << SCALE_SHIFT);
	assign pos1  = la1 + ivl_s;

	// Window geometry on the current cell size
	assign cs_s    = $signed(AW'(cs_q));
	assign half_s  = $signed(AW'(cs_q >> 1));
	assign right_s = ph_q + cs_s;
	assign gap     = right_s - pos_q;
	assign err_full = pos_q - (ph_q + half_s);

	// Steps over the window: ceil((pos - right) / cs) = (pos - ph - 1) / cs
	assign dvd_s   = pos_q - ph_q - AW'(1);
	assign ph_adv  = pos_q - $signed(AW'(div_rem) + AW'(1));
	assign cnt_adv = (div_quo >= DIV_W'(MAX_CELLS - 1)) ? COUNT_W'(MAX_CELLS)
		: div_quo[COUNT_W-1:0] + COUNT_W'(1);

	// Correction ratio picked by the sign of the error
	assign err_neg = err_q[ERR_W-1];
	assign mag     = err_neg ? ERR_W'(-err_q) : ERR_W'(err_q);
	assign num_sel = err_neg ? cfg.slow_num : cfg.fast_num;
	assign den_sel = err_neg ? cfg.slow_den : cfg.fast_den;
	assign err_sat = (32'(mag) > 32'(ERR_SAT)) ? ERR_SAT : ERR_OUT_W'(mag);

	// Shared divider
	assign div_start    = cmd.step_start | cmd.corr_start;
	assign div_dividend = cmd.step_start ? dvd_s[DIV_W-1:0]
		: DIV_W'(prod_q) << (DIV_W - CORR_W);
	assign div_divisor  = cmd.step_start ? cs_q : CS_W'(den_sel);
	assign div_iters    = cmd.step_start ? CNT_W'(DIV_W) : CNT_W'(CORR_W);

	fpcs_div #(
		.DIV_W (DIV_W),
		.DVS_W (CS_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.iters    (div_iters),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// New cell size, truncated toward zero, then clamped
	assign term     = (den_sel == '0) ? '0 : div_quo[CORR_W-1:0];
	assign cs_ext   = $signed(NW'(cs_q));
	assign term_ext = $signed(NW'(term));
	assign cs_new   = err_neg ? cs_ext - term_ext : cs_ext + term_ext;
	assign lo_ext   = $signed(NW'(lim_lo));
	assign hi_ext   = $signed(NW'(lim_hi));
	assign cs_clamp = (cs_new < lo_ext) ? lo_ext : ((cs_new > hi_ext) ? hi_ext : cs_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wphase_q <= '0;
			lphase_q <= '0;
			cs_q     <= CS_RST;
		end else begin
			if (cmd.commit_bad) begin
				wphase_q <= ph_q[PHASE_W-1:0];
				lphase_q <= pos_q[PHASE_W-1:0];
			end
			if (cmd.finish) begin
				wphase_q <= right_s[PHASE_W-1:0];
				lphase_q <= pos_q[PHASE_W-1:0];
			end
			if (reload) cs_q <= CS_W'(reload_nominal) << SCALE_SHIFT;
			if (cmd.apply) cs_q <= cs_clamp[CS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			intv_q <= in_interval;
			corr_q <= in_corr;
		end
		if (cmd.prep) begin
			ph_q    <= ph1;
			pos_q   <= pos1;
			count_q <= COUNT_W'(1);
		end
		if (cmd.zero_step) begin
			ph_q    <= pos_q;
			count_q <= COUNT_W'(MAX_CELLS);
		end
		if (cmd.adv) begin
			ph_q    <= ph_adv;
			count_q <= cnt_adv;
		end
		if (cmd.commit_bad) begin
			res_count_q <= '0;
			res_bad_q   <= 1'b1;
			res_err_q   <= ERR_NONE;
		end
		if (cmd.finish) begin
			res_count_q <= reject(cfg.rej_mode, count_q, gap > half_s);
			res_bad_q   <= 1'b0;
			res_err_q   <= ERR_NONE;
			err_q       <= err_full[ERR_W-1:0];
		end
		if (cmd.mul) begin
			prod_q    <= CORR_W'(mag) * CORR_W'(num_sel);
			res_err_q <= err_sat;
		end
	end

	assign stat.bad      = pos_q < ph_q;
	assign stat.beyond   = pos_q > right_s;
	assign stat.cs_zero  = cs_q == '0;
	assign stat.corr     = corr_q;
	assign stat.den_zero = den_sel == '0;
	assign stat.div_done = div_done;

	assign res_count = res_count_q;
	assign res_bad   = res_bad_q;
	assign res_err   = res_err_q;

`ifndef SYNTHESIS
	a_cell_size_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> (cs_q >= $past(lim_lo) && cs_q <= $past(lim_hi)))
		else $error("corrected cell size outside its limits");
`endif

endmodule

`default_nettype wire

// File: rtl/core/fpcs_ctrl.sv
// ----------------------------------------------------------------------------
// fpcs_ctrl
// Sequencer for one item: place, step, reject, correct, hand off.
// ----------------------------------------------------------------------------
`default_nettype none

module fpcs_ctrl import fpcs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  out_free,
	input  wire stat_t stat,
	output logic       in_ready,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_EVAL,
		S_STEP,
		S_FIN,
		S_MUL,
		S_CSTART,
		S_CWAIT,
		S_APPLY,
		S_OUT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_EVAL;
			end
			S_EVAL: begin
				if (stat.bad) begin
					cmd.commit_bad = 1'b1;
					state_d        = S_OUT;
				end else if (stat.beyond && stat.cs_zero) begin
					cmd.zero_step = 1'b1;
					state_d       = S_FIN;
				end else if (stat.beyond) begin
					cmd.step_start = 1'b1;
					state_d        = S_STEP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_STEP: begin
				if (stat.div_done) begin
					cmd.adv = 1'b1;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = stat.corr ? S_MUL : S_OUT;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = stat.den_zero ? S_APPLY : S_CSTART;
			end
			S_CSTART: begin
				cmd.corr_start = 1'b1;
				state_d        = S_CWAIT;
			end
			S_CWAIT: begin
				if (stat.div_done) begin
					cmd.apply = 1'b1;
					state_d   = S_OUT;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

`ifndef SYNTHESIS
	a_done_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == S_STEP || state_q == S_CWAIT))
		else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

// File: dv/fpcs_cell_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpcs_cell_checker
// Watches the configuration port and both channels of the flux PLL cell
// separator, keeps its own copy of the PLL state, predicts one report per
// accepted interval and compares each delivered report field by field.
// ----------------------------------------------------------------------------

module fpcs_cell_checker import fpcs_pkg::*; #(
	parameter int SHIFT = DEF_SCALE_SHIFT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [INTV_W-1:0]     pulse_interval,
	input  logic                  phase_correct,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [COUNT_W-1:0]    cell_count,
	input  logic                  bad_pulse,
	input  logic [ERR_OUT_W-1:0]  phase_error,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int     CS_W        = 17;
	localparam longint FOLD_AT     = 64'sd512 * 1024 * 1014;
	localparam longint FOLD_BY     = 64'sd256 * 1024 * 1014;

	typedef struct packed {
		logic [COUNT_W-1:0]   cells;
		logic                 bad;
		logic [ERR_OUT_W-1:0] err;
	} cell_report_t;

	// register copy
	logic [NOMINAL_W-1:0] nominal;
	logic [PCT_W-1:0]     pct;
	logic [RATIO_W-1:0]   fast_num, fast_den, slow_num, slow_den;
	logic [REJ_W-1:0]     rej_mode;

	// PLL state
	logic [PHASE_W-1:0] win_phase;
	logic [PHASE_W-1:0] pulse_phase;
	logic [CS_W-1:0]    cell_size;

	cell_report_t cell_reports[$];

	// Advance the PLL by one interval and return the report it gives.
	function automatic cell_report_t count_cells(logic [INTV_W-1:0] ival, logic corr);
		longint span, phase, last, cs, pos, right, center, cells, err, w, lo, hi, steps;
		cell_report_t rep;
		span  = longint'(ival) << SHIFT;
		phase = longint'($signed(win_phase));
		last  = longint'($signed(pulse_phase));
		cs    = longint'(cell_size);
		if (phase > FOLD_AT) begin
			phase -= FOLD_BY;
			last  -= FOLD_BY;
		end
		pos     = last + span;
		rep.err = ERR_NONE;
		if (pos < phase) begin
			win_phase   = phase[PHASE_W-1:0];
			pulse_phase = pos[PHASE_W-1:0];
			rep.cells   = '0;
			rep.bad     = 1'b1;
			return rep;
		end
		cells = 1;
		right = phase + cs;
		if (pos > right) begin
			if (cs > 0) begin
				steps = (pos - right + cs - 1) / cs;
				phase += steps * cs;
				cells += steps;
			end else begin
				phase = pos;
				cells = MAX_CELLS;
			end
			right = phase + cs;
		end
		if (cells > MAX_CELLS)
			cells = MAX_CELLS;
		center = phase + cs / 2;

		if (rej_mode == REJ_GCR) begin
			if (cells == 3)
				cells = (right - pos > cs / 2) ? 2 : 4;
			if (cells == 5)
				cells = (right - pos > cs / 2) ? 4 : 6;
		end else if (rej_mode == REJ_FM) begin
			if (cells == 1)
				cells = 2;
			if (cells == 3)
				cells = (right - pos > cs / 2) ? 2 : 4;
			if (cells > 4)
				cells = 4;
		end

		if (corr) begin
			err = pos - center;
			if (err >= 0) begin
				if (fast_den != 0)
					cs += (err * longint'(fast_num)) / longint'(fast_den);
			end else if (slow_den != 0) begin
				cs += (err * longint'(slow_num)) / longint'(slow_den);
			end
			w  = (longint'(nominal) * longint'(pct)) / 100;
			lo = (longint'(nominal) - w) << SHIFT;
			hi = (longint'(nominal) + w) << SHIFT;
			if (cs < lo)
				cs = lo;
			if (cs > hi)
				cs = hi;
			cell_size = cs[CS_W-1:0];
			if (err < 0)
				err = -err;
			rep.err = (err > longint'(ERR_SAT)) ? ERR_SAT : err[ERR_OUT_W-1:0];
		end

		pulse_phase = pos[PHASE_W-1:0];
		win_phase   = right[PHASE_W-1:0];
		rep.cells   = cells[COUNT_W-1:0];
		rep.bad     = 1'b0;
		return rep;
	endfunction

	task automatic flag(input string field, input logic [15:0] want, input logic [15:0] got);
		fail_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_report_t want;
		if (!arst_n) begin
			nominal     = NOMINAL_RST;
			pct         = WINDOW_RST;
			fast_num    = FAST_NUM_RST;
			fast_den    = FAST_DEN_RST;
			slow_num    = SLOW_NUM_RST;
			slow_den    = SLOW_DEN_RST;
			rej_mode    = REJ_NONE;
			win_phase   = '0;
			pulse_phase = '0;
			cell_size   = CS_W'(NOMINAL_RST) << SHIFT;
			cell_reports.delete();
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_NOMINAL: begin
						nominal   = cfg_data[NOMINAL_W-1:0];
						cell_size = CS_W'(cfg_data[NOMINAL_W-1:0]) << SHIFT;
					end
					REG_WINDOW:   pct      = cfg_data[PCT_W-1:0];
					REG_FAST_NUM: fast_num = cfg_data[RATIO_W-1:0];
					REG_FAST_DEN: fast_den = cfg_data[RATIO_W-1:0];
					REG_SLOW_NUM: slow_num = cfg_data[RATIO_W-1:0];
					REG_SLOW_DEN: slow_den = cfg_data[RATIO_W-1:0];
					REG_REJ_MODE: rej_mode = cfg_data[REJ_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (cell_reports.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected report, expected none, got cells %0d bad %0d err %0d",
						$time, cell_count, bad_pulse, phase_error);
				end else begin
					want = cell_reports.pop_front();
					if (cell_count !== want.cells)
						flag("cell_count", 16'(want.cells), 16'(cell_count));
					if (bad_pulse !== want.bad)
						flag("bad_pulse", 16'(want.bad), 16'(bad_pulse));
					if (phase_error !== want.err)
						flag("phase_error", want.err, phase_error);
				end
			end
			if (in_valid && in_ready)
				cell_reports.push_back(count_cells(pulse_interval, phase_correct));
			pending = cell_reports.size();
		end
	end

endmodule

// File: dv/tb_flux_pll_cell_separator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flux_pll_cell_separator
// Drives flux intervals into the cell separator under a series of register
// setups and random stalls on both channels; a separate checker predicts and
// compares every report, and this module prints the verdict.
// ----------------------------------------------------------------------------

module tb_flux_pll_cell_separator;
	import fpcs_pkg::*;

	// Long receiver hold-off, long enough to back the block up into its input
	localparam int     LONG_HOLD  = 300;
	// Ticks fed before the window phase must have crossed the fold limit
	localparam longint FOLD_TICKS = 64'd34_000_000;
	// Cycles to let pass once the last report is in
	localparam int     TAIL_WAIT  = 80;

	logic clk = 1'b0;
	logic arst_n;

	logic                  in_valid;
	logic                  in_ready;
	logic [INTV_W-1:0]     pulse_interval;
	logic                  phase_correct;
	logic                  out_valid;
	logic                  out_ready;
	logic [COUNT_W-1:0]    cell_count;
	logic                  bad_pulse;
	logic [ERR_OUT_W-1:0]  phase_error;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int     fail_count;
	int     pending;

	// stimulus knobs shared between the sender and the receiver process
	int     cur_nominal;
	int     send_idle_pct;
	int     recv_idle_pct;
	bit     hold_request;
	longint ticks_fed;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	flux_pll_cell_separator u_dut (.*);

	fpcs_cell_checker u_checker (.*);

	// Hard stop in case a handshake never completes
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Pick an interval for the current nominal cell. Most are well-formed
	// (a whole number of cells plus jitter of up to a third of a cell); the
	// rest are sub-cell intervals that tend to land before the window, raw
	// noise over the whole field, and values at both ends of the field.
	function automatic logic [INTV_W-1:0] pick_interval(int kmin, int kmax, int wf_pct);
		int roll, jit, v;
		roll = $urandom_range(0, 99);
		jit  = cur_nominal / 3;
		if (roll < wf_pct)
			v = $urandom_range(kmin, kmax) * cur_nominal + $urandom_range(0, 2 * jit) - jit;
		else if (roll < wf_pct + 10)
			v = $urandom_range(0, cur_nominal);
		else if (roll < wf_pct + 20)
			v = $urandom_range(0, 65535);
		else
			v = ($urandom_range(0, 1) != 0) ? 65535 - $urandom_range(0, 15)
				: $urandom_range(0, 15);
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[INTV_W-1:0];
	endfunction

	// Offer one item, after a random gap if this phase idles the sender, and
	// hold it until the block takes it.
	task automatic push_interval(input logic [INTV_W-1:0] ival, input logic corr);
		int gap;
		@(negedge clk);
		if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		pulse_interval <= ival;
		phase_correct  <= corr;
		ticks_fed += ival;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every report owed has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// One random phase: drain, load a full register setup, then stream items.
	// With to_fold set, keep going on near full-scale intervals until the phase
	// has crossed the fold limit; with long_hold set, stall the receiver for a
	// long stretch a third of the way in.
	task automatic run_phase(input int nom, input int pct, input int fn, input int fd,
		input int sn, input int sd, input int rej, input int n_items,
		input int send_pct, input int recv_pct, input bit to_fold, input bit long_hold);
		int done;
		logic [INTV_W-1:0] ival;
		drain();
		write_reg(REG_NOMINAL, CFG_DATA_W'(nom));
		write_reg(REG_WINDOW, CFG_DATA_W'(pct));
		write_reg(REG_FAST_NUM, CFG_DATA_W'(fn));
		write_reg(REG_FAST_DEN, CFG_DATA_W'(fd));
		write_reg(REG_SLOW_NUM, CFG_DATA_W'(sn));
		write_reg(REG_SLOW_DEN, CFG_DATA_W'(sd));
		write_reg(REG_REJ_MODE, CFG_DATA_W'(rej));
		cur_nominal   = nom;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		done = 0;
		while (done < n_items || (to_fold && ticks_fed < FOLD_TICKS)) begin
			if (long_hold && done == n_items / 3)
				hold_request = 1'b1;
			ival = to_fold ? pick_interval(16, 16, 100) : pick_interval(1, 8, 70);
			push_interval(ival, $urandom_range(0, 3) != 0);
			done++;
		end
	endtask

	// Receiver: random bursts of stall, plus the long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (recv_idle_pct != 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		pulse_interval = '0;
		phase_correct  = 1'b0;
		out_ready      = 1'b0;
		cfg_write_en   = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		cur_nominal    = int'(NOMINAL_RST);
		send_idle_pct  = 20;
		recv_idle_pct  = 20;
		hold_request   = 1'b0;
		ticks_fed      = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part on the reset setup (96-tick cell, no rejection).
		// Zero intervals, an exact cell, a half cell, sub-cell intervals that
		// fall before the window, and full-scale intervals that saturate the
		// cell count, with correction both on and off.
		push_interval(16'd0, 1'b0);
		push_interval(16'd0, 1'b1);
		push_interval(16'd96, 1'b1);
		push_interval(16'd48, 1'b1);
		push_interval(16'd10, 1'b1);
		push_interval(16'd5, 1'b0);
		push_interval(16'd192, 1'b1);
		push_interval(16'hFFFF, 1'b1);
		push_interval(16'hFFFF, 1'b0);
		push_interval(16'd288, 1'b0);
		push_interval(16'd480, 1'b1);

		// GCR rejection: three and five cells, pulse early and late in the window
		drain();
		write_reg(REG_REJ_MODE, CFG_DATA_W'(REJ_GCR));
		push_interval(16'd270, 1'b0);
		push_interval(16'd310, 1'b0);
		push_interval(16'd460, 1'b1);
		push_interval(16'd500, 1'b1);

		// FM rejection: one cell widens, three splits, long runs cap at four
		drain();
		write_reg(REG_REJ_MODE, CFG_DATA_W'(REJ_FM));
		push_interval(16'd96, 1'b0);
		push_interval(16'd288, 1'b0);
		push_interval(16'd600, 1'b1);
		push_interval(16'd100, 1'b1);

		// Random phases. Register extremes first: widest cell, a 50 percent window
		// and the steepest ratios, then a one-tick cell, a one percent window and
		// null ratios.
		run_phase(4095, 50, 15, 1, 15, 1, REJ_GCR, 25, 30, 30, 1'b0, 1'b0);
		run_phase(1, 1, 0, 15, 0, 15, REJ_FM, 20, 0, 30, 1'b0, 1'b0);
		// Zero cell size, both denominators zero, unused rejection mode
		run_phase(0, 45, 9, 0, 6, 0, 3, 12, 40, 0, 1'b0, 1'b0);
		// Typical FM-style setup with a zero slow denominator; the receiver
		// holds off long enough for the block to stall its input
		run_phase(80, 18, 1, 2, 3, 0, REJ_FM, 40, 25, 25, 1'b0, 1'b1);
		// GCR with a zero fast denominator
		run_phase(200, 25, 7, 0, 5, 9, REJ_GCR, 25, 10, 30, 1'b0, 1'b0);
		// Long intervals until the phase folds and at least ten items have gone in
		run_phase(4095, 30, 3, 5, 2, 3, REJ_NONE, 10, 5, 5, 1'b1, 1'b0);
		// Last part runs with no idling on either side
		run_phase(2730, 12, 10, 7, 11, 13, REJ_GCR, 20, 0, 0, 1'b0, 1'b0);

		drain();
		repeat (TAIL_WAIT) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
